>>> sv/spatial_hash_grid_index_core_assert.svh
// ----------------------------------------------------------------------------
// Spatial hash grid index assertion macros
// Shorthand for the concurrent checks used in the grid index RTL.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_HASH_GRID_INDEX_CORE_ASSERT_SVH
`define SPATIAL_HASH_GRID_INDEX_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/shg_pkg.sv
// ----------------------------------------------------------------------------
// Spatial hash grid index package
// Shared constants, default sizes and code types of the grid index.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int unsigned MAX_SLOTS_DEF  = 64;
    localparam int unsigned ID_BITS_DEF    = 10;
    localparam int unsigned COORD_BITS_DEF = 24;
    localparam int unsigned SEQ_BITS_DEF   = 32;

    localparam int unsigned FRAC_BITS      = 8;
    localparam int unsigned RESULT_CAP     = 64;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CELL_SIZE_RST  = 16;
    localparam int unsigned MODE_W         = 3;
    localparam int unsigned KIND_W         = 3;
    localparam int unsigned FOUND_W        = 10;
    localparam int unsigned CNT_W          = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_MOVE   = 3'd2,
        MODE_RADIUS = 3'd3,
        MODE_RECT   = 3'd4,
        MODE_CLEAR  = 3'd5,
        MODE_COUNT  = 3'd6
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE    = 3'd0,
        KIND_MATCH   = 3'd1,
        KIND_NOMATCH = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_COUNT   = 3'd4
    } t_kind;

endpackage

>>> sv/spatial_hash_grid_index_core.sv
// ----------------------------------------------------------------------------
// Spatial hash grid index core
// Slot table of entities filed by grid cell, with maintenance and ordered
// radius and rectangle queries.
// ----------------------------------------------------------------------------
// One input word is handled at a time. Insert and remove first resolve two
// grid cells, and move and both queries four, on a shared bit-serial divider.
// Insert, remove and move then sweep the slot memory once, one slot a cycle,
// followed by an append step when an entry is to be added. A query sweeps once
// to test every slot, then once per reported match to pick the next smallest
// (cell x, cell y, sequence, slot) key, up to RESULT_CAP matches. Clear, count
// and the unused mode skip the divider and answer directly. No clearing pass
// is needed after reset. The output register lets the next word be taken
// while the final result of the previous one is still held.
`include "spatial_hash_grid_index_core_assert.svh"

module spatial_hash_grid_index_core #(
    parameter int unsigned MAX_SLOTS  = shg_pkg::MAX_SLOTS_DEF,
    parameter int unsigned ID_BITS    = shg_pkg::ID_BITS_DEF,
    parameter int unsigned COORD_BITS = shg_pkg::COORD_BITS_DEF,
    parameter int unsigned SEQ_BITS   = shg_pkg::SEQ_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [shg_pkg::MODE_W-1:0]    i_mode,
    input  logic [ID_BITS-1:0]            i_entity_id,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic signed [COORD_BITS-1:0]  i_old_x,
    input  logic signed [COORD_BITS-1:0]  i_old_y,
    input  logic signed [COORD_BITS-1:0]  i_extent_w,
    input  logic signed [COORD_BITS-1:0]  i_extent_h,
    input  logic                          i_cfg_we,
    input  logic [shg_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [shg_pkg::KIND_W-1:0]    o_kind,
    output logic [shg_pkg::FOUND_W-1:0]   o_found_id,
    output logic [shg_pkg::CNT_W-1:0]     o_slot_count,
    output logic                          o_last
);
    import shg_pkg::*;

    localparam int unsigned CB  = COORD_BITS;
    localparam int unsigned AW  = $clog2(MAX_SLOTS);
    localparam int unsigned CW  = COORD_BITS - FRAC_BITS;
    localparam int unsigned BW  = CW + 1;
    localparam int unsigned NW  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned EMW = $clog2(RESULT_CAP + 1);
    localparam int unsigned EW  = ID_BITS + 2 * COORD_BITS + 2 * CW + SEQ_BITS;
    localparam int unsigned KW  = 2 * CW + SEQ_BITS + AW;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV    = 8'b0000_0010,
        S_SWEEP  = 8'b0000_0100,
        S_APPEND = 8'b0000_1000,
        S_FILTER = 8'b0001_0000,
        S_SELECT = 8'b0010_0000,
        S_EMIT   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_cell_size;
    t_mode                   r_mode;
    logic [ID_BITS-1:0]      r_id;
    logic signed [CB-1:0]    r_px, r_py, r_ox, r_oy, r_ew, r_eh;
    logic [1:0]              r_k;
    logic                    r_div_go;
    logic signed [BW-1:0]    r_c [4];
    logic [MAX_SLOTS-1:0]    r_valid;
    logic [MAX_SLOTS-1:0]    r_match;
    logic [NW-1:0]           r_count;
    logic [SEQ_BITS-1:0]     r_seq;
    logic [AW-1:0]           r_addr;
    logic                    r_issue;
    logic                    r_d_vld;
    logic [AW-1:0]           r_d_idx;
    logic                    r_d_last;
    logic                    r_free_found;
    logic [AW-1:0]           r_free_idx;
    logic [NW-1:0]           r_nmatch;
    logic [EMW-1:0]          r_emitted;
    logic                    r_best_vld;
    logic [KW-1:0]           r_best_key;
    logic [AW-1:0]           r_best_idx;
    logic [ID_BITS-1:0]      r_best_id;
    t_kind                   r_resp_kind;
    logic                    r_out_valid;
    logic [KIND_W-1:0]       r_out_kind;
    logic [FOUND_W-1:0]      r_out_id;
    logic [CNT_W-1:0]        r_out_cnt;
    logic                    r_out_last;

    logic                    accept, can_load, is_query, needs_div;
    logic [1:0]              div_last_k;
    logic signed [CB:0]      xe, ye, oxe, oye, we, he;
    logic signed [CB:0]      div_in;
    logic                    div_done;
    logic signed [BW-1:0]    div_out;
    logic [EW-1:0]           mem_rd, mem_wd;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic [ID_BITS-1:0]      e_id;
    logic signed [CB-1:0]    e_px, e_py;
    logic signed [CW-1:0]    e_cx, e_cy;
    logic [SEQ_BITS-1:0]     e_seq;
    logic                    d_v, hit, drop, drop_en, app_en;
    logic [CW-1:0]           drop_cx, drop_cy;
    logic [KW-1:0]           key;
    logic                    better, emit_last;
    logic                    q_valid, q_last, q_hit;
    logic [AW-1:0]           q_idx;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign can_load  = !r_out_valid || !i_out_stall;
    assign is_query  = (r_mode == MODE_RADIUS) || (r_mode == MODE_RECT);
    assign needs_div = t_mode'(i_mode) inside {MODE_INSERT, MODE_REMOVE, MODE_MOVE,
                                               MODE_RADIUS, MODE_RECT};
    assign div_last_k = ((r_mode == MODE_INSERT) || (r_mode == MODE_REMOVE)) ? 2'd1 : 2'd3;

    always_comb begin
        xe  = {r_px[CB-1], r_px};
        ye  = {r_py[CB-1], r_py};
        oxe = {r_ox[CB-1], r_ox};
        oye = {r_oy[CB-1], r_oy};
        we  = {r_ew[CB-1], r_ew};
        he  = {r_eh[CB-1], r_eh};
        div_in = xe;
        case (r_k)
            2'd0: begin
                div_in = (r_mode == MODE_RADIUS) ? xe - we : xe;
            end
            2'd1: begin
                div_in = is_query ? xe + we : ye;
            end
            2'd2: begin
                if (r_mode == MODE_RADIUS) begin
                    div_in = ye - we;
                end else if (r_mode == MODE_RECT) begin
                    div_in = ye;
                end else begin
                    div_in = oxe;
                end
            end
            default: begin
                if (r_mode == MODE_RADIUS) begin
                    div_in = ye + we;
                end else if (r_mode == MODE_RECT) begin
                    div_in = ye + he;
                end else begin
                    div_in = oye;
                end
            end
        endcase
    end

    shg_cell_div #(
        .IN_W (COORD_BITS + 1)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_go),
        .i_value     (div_in),
        .i_cell_size (r_cell_size),
        .o_done      (div_done),
        .o_cell      (div_out)
    );

    shg_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (r_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (mem_rd),
        .i_we      (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd)
    );

    always_comb begin
        {e_id, e_px, e_py, e_cx, e_cy, e_seq} = mem_rd;
        d_v     = r_valid[r_d_idx];
        hit     = d_v && (e_id == r_id);
        drop_en = (r_mode == MODE_REMOVE) ||
                  ((r_mode == MODE_MOVE) && ((r_c[2] != r_c[0]) || (r_c[3] != r_c[1])));
        app_en  = (r_mode == MODE_INSERT) ||
                  ((r_mode == MODE_MOVE) && ((r_c[2] != r_c[0]) || (r_c[3] != r_c[1])));
        drop_cx = (r_mode == MODE_MOVE) ? r_c[2][CW-1:0] : r_c[0][CW-1:0];
        drop_cy = (r_mode == MODE_MOVE) ? r_c[3][CW-1:0] : r_c[1][CW-1:0];
        drop    = hit && drop_en && (e_cx == drop_cx) && (e_cy == drop_cy);
        key     = {~e_cx[CW-1], e_cx[CW-2:0], ~e_cy[CW-1], e_cy[CW-2:0], e_seq, r_d_idx};
        better  = r_match[r_d_idx] && (!r_best_vld || (key < r_best_key));
        emit_last = (r_nmatch == NW'(1)) || (r_emitted == EMW'(RESULT_CAP - 1));

        mem_we = 1'b0;
        mem_wa = r_d_idx;
        mem_wd = {e_id, r_px, r_py, e_cx, e_cy, e_seq};
        if ((r_state == S_SWEEP) && r_d_vld && hit) begin
            mem_we = 1'b1;
        end else if ((r_state == S_APPEND) && r_free_found) begin
            mem_we = 1'b1;
            mem_wa = r_free_idx;
            mem_wd = {r_id, r_px, r_py, r_c[0][CW-1:0], r_c[1][CW-1:0], r_seq};
        end
    end

    shg_query_test #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  ((r_state == S_FILTER) && r_d_vld),
        .i_last   (r_d_last),
        .i_idx    (r_d_idx),
        .i_en     (d_v),
        .i_circle (r_mode == MODE_RADIUS),
        .i_px     (e_px),
        .i_py     (e_py),
        .i_cx     (e_cx),
        .i_cy     (e_cy),
        .i_x      (r_px),
        .i_y      (r_py),
        .i_w      (r_ew),
        .i_h      (r_eh),
        .i_bx0    (r_c[0]),
        .i_bx1    (r_c[1]),
        .i_by0    (r_c[2]),
        .i_by1    (r_c[3]),
        .o_valid  (q_valid),
        .o_last   (q_last),
        .o_idx    (q_idx),
        .o_hit    (q_hit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = needs_div ? S_DIV : S_RESP;
                end
            end
            S_DIV: begin
                if (div_done && (r_k == div_last_k)) begin
                    n_state = is_query ? S_FILTER : S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_d_vld && r_d_last) begin
                    n_state = app_en ? S_APPEND : S_RESP;
                end
            end
            S_APPEND: begin
                n_state = S_RESP;
            end
            S_FILTER: begin
                if (q_valid && q_last) begin
                    n_state = ((r_nmatch == '0) && !q_hit) ? S_RESP : S_SELECT;
                end
            end
            S_SELECT: begin
                if (r_d_vld && r_d_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    n_state = emit_last ? S_IDLE : S_SELECT;
                end
            end
            S_RESP: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cell_size <= CFG_W'(CELL_SIZE_RST);
            r_valid     <= '0;
            r_count     <= '0;
            r_seq       <= '0;
            r_issue     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_div_go    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= 1'b0;

            if (i_cfg_we) begin
                r_cell_size <= i_cfg_wdata;
            end

            if (r_issue) begin
                r_d_vld  <= 1'b1;
                r_d_idx  <= r_addr;
                r_d_last <= (r_addr == AW'(MAX_SLOTS - 1));
                if (r_addr == AW'(MAX_SLOTS - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + AW'(1);
                end
            end else begin
                r_d_vld <= 1'b0;
            end

            if (accept) begin
                r_mode       <= t_mode'(i_mode);
                r_id         <= i_entity_id;
                r_px         <= i_pos_x;
                r_py         <= i_pos_y;
                r_ox         <= i_old_x;
                r_oy         <= i_old_y;
                r_ew         <= i_extent_w;
                r_eh         <= i_extent_h;
                r_k          <= 2'd0;
                r_div_go     <= needs_div;
                r_nmatch     <= '0;
                r_emitted    <= '0;
                r_free_found <= 1'b0;
                r_best_vld   <= 1'b0;
                r_resp_kind  <= KIND_DONE;
                if (t_mode'(i_mode) == MODE_CLEAR) begin
                    r_valid <= '0;
                    r_count <= '0;
                end
                if (t_mode'(i_mode) == MODE_COUNT) begin
                    r_resp_kind <= KIND_COUNT;
                end
            end

            if ((r_state == S_DIV) && div_done) begin
                r_c[r_k] <= div_out;
                if (r_k != div_last_k) begin
                    r_k      <= r_k + 2'd1;
                    r_div_go <= 1'b1;
                end else begin
                    r_addr  <= '0;
                    r_issue <= 1'b1;
                end
            end

            if ((r_state == S_SWEEP) && r_d_vld) begin
                if (drop) begin
                    r_valid[r_d_idx] <= 1'b0;
                    r_count          <= r_count - NW'(1);
                end
                if (!(d_v && !drop) && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_d_idx;
                end
            end

            if (r_state == S_APPEND) begin
                if (r_free_found) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_count             <= r_count + NW'(1);
                    r_seq               <= r_seq + SEQ_BITS'(1);
                end else begin
                    r_resp_kind <= KIND_FULL;
                end
            end

            if ((r_state == S_FILTER) && q_valid) begin
                r_match[q_idx] <= q_hit;
                if (q_hit) begin
                    r_nmatch <= r_nmatch + NW'(1);
                end
                if (q_last && !q_hit && (r_nmatch == '0)) begin
                    r_resp_kind <= KIND_NOMATCH;
                end
                if (q_last && (q_hit || (r_nmatch != '0))) begin
                    r_addr  <= '0;
                    r_issue <= 1'b1;
                end
            end

            if ((r_state == S_SELECT) && r_d_vld && better) begin
                r_best_vld <= 1'b1;
                r_best_key <= key;
                r_best_idx <= r_d_idx;
                r_best_id  <= e_id;
            end

            if ((r_state == S_EMIT) && can_load) begin
                r_match[r_best_idx] <= 1'b0;
                r_nmatch            <= r_nmatch - NW'(1);
                r_emitted           <= r_emitted + EMW'(1);
                r_best_vld          <= 1'b0;
                if (!emit_last) begin
                    r_addr  <= '0;
                    r_issue <= 1'b1;
                end
            end

            if ((r_state == S_EMIT) && can_load) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= KIND_MATCH;
                r_out_id    <= FOUND_W'(r_best_id);
                r_out_cnt   <= '0;
                r_out_last  <= emit_last;
            end else if ((r_state == S_RESP) && can_load) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= r_resp_kind;
                r_out_id    <= '0;
                r_out_cnt   <= (r_resp_kind == KIND_COUNT) ? CNT_W'(r_count) : '0;
                r_out_last  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_found_id   = r_out_id;
    assign o_slot_count = r_out_cnt;
    assign o_last       = r_out_last;

    `SHG_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE, "accepted word did not start work")
    `SHG_ASSERT_IMP(a_emit_has_best, i_clk, i_rst_n, r_state == S_EMIT, r_best_vld && (r_nmatch != '0), "match emitted with no selected slot")
    `SHG_ASSERT_NXT(a_append_counts, i_clk, i_rst_n, (r_state == S_APPEND) && r_free_found, r_count == $past(r_count) + NW'(1), "append did not grow the slot count")
    `SHG_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_state == S_IDLE, r_count <= NW'(MAX_SLOTS), "slot count above table size")

endmodule

>>> sv/shg_cell_div.sv
// ----------------------------------------------------------------------------
// Grid cell divider
// Computes floor(value / (cell_size * 2^FRAC_BITS)) one quotient bit a cycle.
// ----------------------------------------------------------------------------
module shg_cell_div #(
    parameter int unsigned IN_W = 25
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [IN_W-1:0]                  i_value,
    input  logic [shg_pkg::CFG_W-1:0]               i_cell_size,
    output logic                                    o_done,
    output logic signed [IN_W-shg_pkg::FRAC_BITS-1:0] o_cell
);
    import shg_pkg::*;

    localparam int unsigned QW  = IN_W - FRAC_BITS;
    localparam int unsigned CTW = $clog2(QW + 1);

    logic signed [IN_W-1:0] shifted;
    logic [QW-1:0]          q;
    logic [CFG_W:0]         trial;
    logic [CFG_W:0]         diff;
    logic                   ge;

    logic                   r_busy;
    logic                   r_done;
    logic                   r_neg;
    logic [CTW-1:0]         r_cnt;
    logic [CFG_W-1:0]       r_rem;
    logic [CFG_W-1:0]       r_div;
    logic [QW-1:0]          r_quo;

    assign shifted = i_value >>> FRAC_BITS;
    assign q       = shifted[QW-1:0];
    assign trial   = {r_rem, r_quo[QW-1]};
    assign diff    = trial - {1'b0, r_div};
    assign ge      = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= q[QW-1];
                r_quo  <= q[QW-1] ? ~q : q;
                r_rem  <= '0;
                r_div  <= (i_cell_size == '0) ? CFG_W'(1) : i_cell_size;
                r_cnt  <= CTW'(QW);
            end else if (r_busy) begin
                r_rem <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
                r_quo <= {r_quo[QW-2:0], ge};
                r_cnt <= r_cnt - CTW'(1);
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cell = r_neg ? $signed(~r_quo) : $signed(r_quo);

endmodule

>>> sv/shg_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot table memory
// Single-port-write, single-port-read table with a registered read.
// ----------------------------------------------------------------------------
module shg_slot_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/shg_query_test.sv
// ----------------------------------------------------------------------------
// Query hit test pipeline
// Three-stage cell box, half-open rectangle and exact circle test of a slot.
// ----------------------------------------------------------------------------
module shg_query_test #(
    parameter int unsigned COORD_BITS = 24,
    parameter int unsigned AW         = 6
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    input  logic                                          i_last,
    input  logic [AW-1:0]                                 i_idx,
    input  logic                                          i_en,
    input  logic                                          i_circle,
    input  logic signed [COORD_BITS-1:0]                  i_px,
    input  logic signed [COORD_BITS-1:0]                  i_py,
    input  logic signed [COORD_BITS-shg_pkg::FRAC_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-shg_pkg::FRAC_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0]                  i_x,
    input  logic signed [COORD_BITS-1:0]                  i_y,
    input  logic signed [COORD_BITS-1:0]                  i_w,
    input  logic signed [COORD_BITS-1:0]                  i_h,
    input  logic signed [COORD_BITS-shg_pkg::FRAC_BITS:0] i_bx0,
    input  logic signed [COORD_BITS-shg_pkg::FRAC_BITS:0] i_bx1,
    input  logic signed [COORD_BITS-shg_pkg::FRAC_BITS:0] i_by0,
    input  logic signed [COORD_BITS-shg_pkg::FRAC_BITS:0] i_by1,
    output logic                                          o_valid,
    output logic                                          o_last,
    output logic [AW-1:0]                                 o_idx,
    output logic                                          o_hit
);
    import shg_pkg::*;

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned CW = COORD_BITS - FRAC_BITS;

    logic signed [CB:0] pxe, pye, xe, ye, we, he, dx, dy;
    logic signed [CW:0] cxe, cye;
    logic [CB:0]        dxm, dym, rm;
    logic               inbox, rect_ok, near;
    logic [2*CB:0]      sum;

    logic               r1_vld, r1_last, r1_box, r1_circle, r1_rect, r1_near;
    logic [AW-1:0]      r1_idx;
    logic [CB-1:0]      r1_dx, r1_dy, r1_r;
    logic               r2_vld, r2_last, r2_box, r2_circle, r2_rect, r2_near;
    logic [AW-1:0]      r2_idx;
    logic [2*CB-1:0]    r2_dx2, r2_dy2, r2_r2;
    logic               r3_vld, r3_last, r3_hit;
    logic [AW-1:0]      r3_idx;

    always_comb begin
        pxe = {i_px[CB-1], i_px};
        pye = {i_py[CB-1], i_py};
        xe  = {i_x[CB-1], i_x};
        ye  = {i_y[CB-1], i_y};
        we  = {i_w[CB-1], i_w};
        he  = {i_h[CB-1], i_h};
        cxe = {i_cx[CW-1], i_cx};
        cye = {i_cy[CW-1], i_cy};
        dx  = pxe - xe;
        dy  = pye - ye;
        dxm = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
        dym = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
        rm  = we[CB] ? $unsigned(-we) : $unsigned(we);
        inbox   = i_en && (cxe >= i_bx0) && (cxe <= i_bx1)
                       && (cye >= i_by0) && (cye <= i_by1);
        rect_ok = (pxe >= xe) && (pxe < xe + we) && (pye >= ye) && (pye < ye + he);
        near    = (dxm <= rm) && (dym <= rm);
        sum     = {1'b0, r2_dx2} + {1'b0, r2_dy2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        r1_last   <= i_last;
        r1_idx    <= i_idx;
        r1_box    <= inbox;
        r1_circle <= i_circle;
        r1_rect   <= rect_ok;
        r1_near   <= near;
        r1_dx     <= dxm[CB-1:0];
        r1_dy     <= dym[CB-1:0];
        r1_r      <= rm[CB-1:0];

        r2_last   <= r1_last;
        r2_idx    <= r1_idx;
        r2_box    <= r1_box;
        r2_circle <= r1_circle;
        r2_rect   <= r1_rect;
        r2_near   <= r1_near;
        r2_dx2    <= r1_dx * r1_dx;
        r2_dy2    <= r1_dy * r1_dy;
        r2_r2     <= r1_r * r1_r;

        r3_last   <= r2_last;
        r3_idx    <= r2_idx;
        r3_hit    <= r2_box && (r2_circle ? (r2_near && (sum <= {1'b0, r2_r2})) : r2_rect);
    end

    assign o_valid = r3_vld;
    assign o_last  = r3_last;
    assign o_idx   = r3_idx;
    assign o_hit   = r3_hit;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid index core testbench
// Drives maintenance, query, clear and count words through the valid/stall
// channel, predicts every result word from an internal slot table model and
// compares the results in order, under random idling and a long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    import shg_pkg::*;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]         mode;
        logic [9:0]         id;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [23:0] ew;
        logic signed [23:0] eh;
    } t_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] id;
        logic [6:0] cnt;
        logic       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_mode = '0;
    logic [9:0] i_entity_id = '0;
    logic signed [23:0] i_pos_x = '0, i_pos_y = '0, i_old_x = '0, i_old_y = '0;
    logic signed [23:0] i_extent_w = '0, i_extent_h = '0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [2:0] o_kind;
    logic [9:0] o_found_id;
    logic [6:0] o_slot_count;
    logic o_last;

    spatial_hash_grid_index_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_entity_id(i_entity_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_old_x(i_old_x), .i_old_y(i_old_y),
        .i_extent_w(i_extent_w), .i_extent_h(i_extent_h),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kind(o_kind), .o_found_id(o_found_id), .o_slot_count(o_slot_count),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [15:0] grid_cell;
    bit          tbl_valid [SLOTS];
    logic [9:0]  tbl_id [SLOTS];
    longint      tbl_px [SLOTS], tbl_py [SLOTS], tbl_cx [SLOTS], tbl_cy [SLOTS];
    longint unsigned tbl_seq [SLOTS];
    logic [31:0] seq_next;

    t_word   word_queue [$];
    t_result expected_results [$];
    int      errors = 0;
    int      words_sent = 0;
    int      results_seen = 0;
    int      match_words = 0;
    bit      calm = 1'b0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    function automatic longint cell_index(longint p);
        longint d, q;
        d = (grid_cell == 0 ? 1 : longint'(grid_cell)) * 256;
        q = p / d;
        if ((p % d) != 0 && p < 0) q -= 1;
        return q;
    endfunction

    function automatic void refresh_pos(logic [9:0] id, longint x, longint y);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_id[i] == id) begin
                tbl_px[i] = x;
                tbl_py[i] = y;
            end
    endfunction

    function automatic void free_in_cell(logic [9:0] id, longint cx, longint cy);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_id[i] == id && tbl_cx[i] == cx && tbl_cy[i] == cy)
                tbl_valid[i] = 0;
    endfunction

    function automatic bit add_slot(logic [9:0] id, longint x, longint y);
        for (int i = 0; i < SLOTS; i++)
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1;
                tbl_id[i] = id;
                tbl_px[i] = x;
                tbl_py[i] = y;
                tbl_cx[i] = cell_index(x);
                tbl_cy[i] = cell_index(y);
                tbl_seq[i] = seq_next;
                seq_next = seq_next + 1;
                return 1;
            end
        return 0;
    endfunction

    function automatic bit key_less(int a, int b);
        if (tbl_cx[a] != tbl_cx[b]) return tbl_cx[a] < tbl_cx[b];
        if (tbl_cy[a] != tbl_cy[b]) return tbl_cy[a] < tbl_cy[b];
        if (tbl_seq[a] != tbl_seq[b]) return tbl_seq[a] < tbl_seq[b];
        return a < b;
    endfunction

    function automatic void push_result(t_kind k, logic [9:0] id, logic [6:0] c, bit l);
        t_result r;
        r.kind = k;
        r.id = id;
        r.cnt = c;
        r.last = l;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_query(bit circle, longint x, longint y, longint w,
                                          longint h);
        longint bx0, bx1, by0, by1, dx, dy;
        int picks [$];
        int n, j;
        bit ok;
        if (circle) begin
            bx0 = cell_index(x - w); bx1 = cell_index(x + w);
            by0 = cell_index(y - w); by1 = cell_index(y + w);
        end else begin
            bx0 = cell_index(x); bx1 = cell_index(x + w);
            by0 = cell_index(y); by1 = cell_index(y + h);
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i]) continue;
            if (tbl_cx[i] < bx0 || tbl_cx[i] > bx1) continue;
            if (tbl_cy[i] < by0 || tbl_cy[i] > by1) continue;
            if (circle) begin
                dx = tbl_px[i] - x; if (dx < 0) dx = -dx;
                dy = tbl_py[i] - y; if (dy < 0) dy = -dy;
                if (w < 0) w = -w;
                ok = dx <= w && dy <= w && dx * dx + dy * dy <= w * w;
            end else begin
                ok = tbl_px[i] >= x && tbl_px[i] < x + w && tbl_py[i] >= y && tbl_py[i] < y + h;
            end
            if (!ok) continue;
            j = 0;
            while (j < picks.size() && !key_less(i, picks[j])) j++;
            picks.insert(j, i);
        end
        n = picks.size();
        if (n == 0) begin
            push_result(KIND_NOMATCH, '0, '0, 1);
            return;
        end
        match_words++;
        if (n > RESULT_CAP) n = RESULT_CAP;
        for (int k = 0; k < n; k++) push_result(KIND_MATCH, tbl_id[picks[k]], '0, k == n - 1);
    endfunction

    function automatic void predict_word(t_word w);
        longint px, py, ox, oy;
        bit ok;
        int c;
        ok = 1;
        px = w.px; py = w.py; ox = w.ox; oy = w.oy;
        case (w.mode)
            MODE_INSERT: begin
                refresh_pos(w.id, px, py);
                ok = add_slot(w.id, px, py);
            end
            MODE_REMOVE: begin
                refresh_pos(w.id, px, py);
                free_in_cell(w.id, cell_index(px), cell_index(py));
            end
            MODE_MOVE: begin
                refresh_pos(w.id, px, py);
                if (cell_index(ox) != cell_index(px) || cell_index(oy) != cell_index(py)) begin
                    free_in_cell(w.id, cell_index(ox), cell_index(oy));
                    ok = add_slot(w.id, px, py);
                end
            end
            MODE_RADIUS: begin
                predict_query(1, px, py, w.ew, 0);
                return;
            end
            MODE_RECT: begin
                predict_query(0, px, py, w.ew, w.eh);
                return;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 0;
            end
            MODE_COUNT: begin
                c = 0;
                for (int i = 0; i < SLOTS; i++) c += tbl_valid[i];
                push_result(KIND_COUNT, '0, c[6:0], 1);
                return;
            end
            default: ;
        endcase
        push_result(ok ? KIND_DONE : KIND_FULL, '0, '0, 1);
    endfunction

    // Sender.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_word(word_queue.pop_front());
                words_sent++;
            end
            if ((!i_in_valid || !o_in_stall) && word_queue.size() > 0 &&
                (calm || $urandom_range(99) >= 36)) begin
                i_in_valid  <= 1'b1;
                i_mode      <= word_queue[0].mode;
                i_entity_id <= word_queue[0].id;
                i_pos_x     <= word_queue[0].px;
                i_pos_y     <= word_queue[0].py;
                i_old_x     <= word_queue[0].ox;
                i_old_y     <= word_queue[0].oy;
                i_extent_w  <= word_queue[0].ew;
                i_extent_h  <= word_queue[0].eh;
            end else if (!i_in_valid || !o_in_stall) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word kind %0d id %0d", $time, o_kind,
                             o_found_id);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r != {o_kind, o_found_id, o_slot_count, o_last}) begin
                        errors++;
                        $display("%0t: expected kind %0d id %0d count %0d last %0d, got %0d %0d %0d %0d",
                                 $time, exp_r.kind, exp_r.id, exp_r.cnt, exp_r.last,
                                 o_kind, o_found_id, o_slot_count, o_last);
                    end
                end
            end
            if (hold_req && hold_left == 0) hold_left <= 300;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT) begin
                $display("** spatial_hash_grid_index_core: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_word make_word(t_mode m, logic [9:0] id, int px, int py, int ox,
                                        int oy, int ew, int eh);
        t_word w;
        w.mode = m; w.id = id;
        w.px = 24'(px); w.py = 24'(py); w.ox = 24'(ox); w.oy = 24'(oy);
        w.ew = 24'(ew); w.eh = 24'(eh);
        return w;
    endfunction

    function automatic void queue_word(t_word w);
        word_queue.insert(word_queue.size(), w);
    endfunction

    function automatic int rnd_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic drain();
        while (word_queue.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (8000) @(posedge i_clk);
    endtask

    task automatic set_cell(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        grid_cell = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count, int span, int extent);
        t_word w;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            w = make_word(MODE_INSERT, 10'($urandom_range(15)), rnd_coord(span),
                          rnd_coord(span), rnd_coord(span), rnd_coord(span),
                          $urandom_range(extent), $urandom_range(extent));
            if (r < 35) w.mode = MODE_INSERT;
            else if (r < 45) w.mode = MODE_REMOVE;
            else if (r < 58) w.mode = MODE_MOVE;
            else if (r < 75) w.mode = MODE_RADIUS;
            else if (r < 90) w.mode = MODE_RECT;
            else if (r < 93) w.mode = MODE_CLEAR;
            else if (r < 98) w.mode = MODE_COUNT;
            else w.mode = 3'd7;
            if (r % 7 == 0) begin
                w.id = 10'($urandom);
                w.px = 24'($urandom); w.py = 24'($urandom);
                w.ox = 24'($urandom); w.oy = 24'($urandom);
                w.ew = 24'($urandom); w.eh = 24'($urandom);
            end
            queue_word(w);
        end
    endtask

    initial begin
        grid_cell = CELL_SIZE_RST;
        seq_next = '0;
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at reset cell size.
        queue_word(make_word(MODE_COUNT, 0, 0, 0, 0, 0, 0, 0));
        queue_word(make_word(MODE_RADIUS, 0, 0, 0, 0, 0, 1000, 0));
        queue_word(make_word(MODE_INSERT, 10'h3FF, 24'sh7FFFFF, -8388608, 0, 0, 0, 0));
        queue_word(make_word(MODE_INSERT, 0, -8388608, 24'sh7FFFFF, 0, 0, 0, 0));
        queue_word(make_word(MODE_INSERT, 5, 100, 200, 0, 0, 0, 0));
        queue_word(make_word(MODE_INSERT, 5, 4000, 4100, 0, 0, 0, 0));
        queue_word(make_word(MODE_MOVE, 6, 9000, 9000, 100, 200, 0, 0));
        queue_word(make_word(MODE_MOVE, 6, 9010, 9010, 9000, 9000, 0, 0));
        queue_word(make_word(MODE_RADIUS, 0, 0, 0, 0, 0, 24'sh7FFFFF, 0));
        queue_word(make_word(MODE_RADIUS, 0, 0, 0, 0, 0, -5, 0));
        queue_word(make_word(MODE_RECT, 0, -8388608, -8388608, 0, 0,
                             24'sh7FFFFF, 24'sh7FFFFF));
        queue_word(make_word(MODE_RECT, 0, 9010, 9010, 0, 0, 1, -1));
        queue_word(make_word(MODE_REMOVE, 5, 4000, 4100, 0, 0, 0, 0));
        queue_word(make_word(MODE_COUNT, 0, 0, 0, 0, 0, 0, 0));
        queue_word(make_word(t_mode'(3'd7), 0, 0, 0, 0, 0, 0, 0));
        queue_word(make_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 66; i++)
            queue_word(make_word(MODE_INSERT, i[9:0], i * 40, 0, 0, 0, 0, 0));
        queue_word(make_word(MODE_RECT, 0, -100, -100, 0, 0, 24'sh7FFFFF, 1000));
        queue_word(make_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        drain();

        // Small cells, no idling, then a long output hold while words keep coming.
        set_cell(16'd1);
        calm = 1'b1;
        random_phase(14, 3000, 2000);
        drain();
        calm = 1'b0;
        hold_req = 1'b1;
        random_phase(10, 3000, 2000);
        wait (hold_left > 0);
        hold_req = 1'b0;
        drain();

        set_cell(16'd0);
        random_phase(12, 2000, 1500);
        drain();
        set_cell(16'hFFFF);
        random_phase(10, 800000, 600000);
        drain();
        set_cell(16'd16);
        random_phase(10, 20000, 8000);
        drain();

        $display("Sent %0d words and checked %0d result words; %0d queries matched.",
                 words_sent, results_seen, match_words);
        $display("Cell sizes 16, 1, 0, 65535 and 16 were used, with a full table reached.");
        if (errors == 0) begin
            $display("** spatial_hash_grid_index_core: PASSED **");
        end else begin
            $display("** spatial_hash_grid_index_core: FAILED **");
        end
        $finish;
    end
endmodule
